@@ sv/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, codes and constants of the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // default geometry
  localparam int unsigned DEF_CACHE_BYTES  = 256 * 1024;
  localparam int unsigned DEF_WORD_BYTES   = 4;
  localparam int unsigned DEF_MAX_WAYS     = 16;
  localparam int unsigned DEF_ADDRESS_BITS = 32;

  // fixed field widths
  localparam int unsigned AGE_W        = 4;
  localparam int unsigned WAY_W        = 4;
  localparam int unsigned SET_OUT_W    = 16;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned ADDR_FIELD_W = 32;
  localparam int unsigned GEO_W        = 6;
  localparam int unsigned OFF_W        = 7;
  localparam int unsigned NBLK_W       = 3;
  localparam int unsigned WAYS_LOG_CAP = 4;
  localparam int unsigned SET_BITS_CAP = 16;
  localparam int unsigned MAX_BYTES    = 16;
  localparam int unsigned RESULT_LIMIT = 5;

  // stream and register port geometry
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;

  // write policies
  localparam logic [1:0] POL_WB   = 2'd0;
  localparam logic [1:0] POL_WTA  = 2'd1;
  localparam logic [1:0] POL_WTNA = 2'd2;

  // register indexes
  localparam logic [1:0] REG_BLOCK_WORDS_LOG = 2'd0;
  localparam logic [1:0] REG_WAYS_LOG        = 2'd1;
  localparam logic [1:0] REG_WRITE_POLICY    = 2'd2;

  // access kinds
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  // outcome of the tag lookup over one set word
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim_way;
    logic             victim_dirty;
  } lookup_t;

  // elaboration-time helper
  function automatic int floor_log2(input longint unsigned v);
    int r;
    longint unsigned t;
    r = 0;
    t = v;
    for (int i = 0; i < 64; i++) begin
      if (t > 1) begin
        t = t >> 1;
        r = r + 1;
      end
    end
    return r;
  endfunction

endpackage

@@ sv/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sacl_lookup.sv @@
// ----------------------------------------------------------------------------
// sacl_lookup
// Tag match, first free way and oldest way over one set word.
// ----------------------------------------------------------------------------
module sacl_lookup
  import sacl_pkg::*;
#(
  parameter int unsigned NWAYS = 16,
  parameter int unsigned TAG_W = 18
) (
  input  logic [NWAYS*(TAG_W+AGE_W+2)-1:0] set_word,
  input  logic [TAG_W-1:0]                 tag,
  input  logic [NWAYS-1:0]                 way_en,
  output lookup_t                          look
);

  localparam int unsigned ENTRY_W   = TAG_W + AGE_W + 2;
  localparam int unsigned AGE_LSB   = TAG_W;
  localparam int unsigned DIRTY_BIT = TAG_W + AGE_W;
  localparam int unsigned VALID_BIT = TAG_W + AGE_W + 1;
  localparam int unsigned LV        = (NWAYS > 1) ? $clog2(NWAYS) : 0;

  logic [ENTRY_W-1:0] ent [NWAYS];
  logic [AGE_W-1:0]   v_age [LV+1][NWAYS];
  logic [WAY_W-1:0]   v_idx [LV+1][NWAYS];
  logic               v_en  [LV+1][NWAYS];

  always_comb begin
    for (int i = 0; i < NWAYS; i++) begin
      ent[i] = set_word[i*ENTRY_W +: ENTRY_W];
    end
  end

  // lowest matching way, lowest free way, and the oldest way's dirty mark
  always_comb begin
    look.hit      = 1'b0;
    look.hit_way  = '0;
    look.free     = 1'b0;
    look.free_way = '0;
    for (int i = NWAYS - 1; i >= 0; i--) begin
      if (way_en[i] && ent[i][VALID_BIT] && (ent[i][TAG_W-1:0] == tag)) begin
        look.hit     = 1'b1;
        look.hit_way = WAY_W'(i);
      end
      if (way_en[i] && !ent[i][VALID_BIT]) begin
        look.free     = 1'b1;
        look.free_way = WAY_W'(i);
      end
    end
    look.victim_way   = v_idx[LV][0];
    look.victim_dirty = 1'b0;
    for (int i = 0; i < NWAYS; i++) begin
      if (v_idx[LV][0] == WAY_W'(i)) begin
        look.victim_dirty = ent[i][DIRTY_BIT];
      end
    end
  end

  // oldest way: pairwise tree, the lower way wins a tie
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int j = 0; j < NWAYS; j++) begin
        v_age[l][j] = '0;
        v_idx[l][j] = '0;
        v_en[l][j]  = 1'b0;
      end
    end
    for (int j = 0; j < NWAYS; j++) begin
      v_age[0][j] = ent[j][AGE_LSB +: AGE_W];
      v_idx[0][j] = WAY_W'(j);
      v_en[0][j]  = way_en[j];
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < (NWAYS >> (l + 1)); j++) begin
        if (v_en[l][2*j+1] && (!v_en[l][2*j] || (v_age[l][2*j+1] > v_age[l][2*j]))) begin
          v_age[l+1][j] = v_age[l][2*j+1];
          v_idx[l+1][j] = v_idx[l][2*j+1];
        end else begin
          v_age[l+1][j] = v_age[l][2*j];
          v_idx[l+1][j] = v_idx[l][2*j];
        end
        v_en[l+1][j] = v_en[l][2*j] | v_en[l][2*j+1];
      end
    end
  end

endmodule

@@ sv/set_assoc_cache_lru_controller.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller
// Tag and state controller of a set-associative cache with age-based LRU
// replacement. Each input word is one read or write access (address and byte
// count, 1 to 16 bytes); the access is split into the cache blocks it
// touches, and one result word per block leaves in ascending address order,
// the last one with out_tlast. A hit touches its way; a miss fills the first
// free way or replaces the oldest one, except a write under write-through
// no-allocate, which leaves the set alone. All tags, ages and dirty marks
// live in one set-wide RAM word per set (all ways side by side), read,
// updated and written back once per block. Steps: an access is accepted
// in idle and split in setup, then each block, up to five, gets a RAM read
// and lookup, then an age update and write-back; a stalled result port
// holds the update step. After reset the block sweeps the RAM once, one set
// per cycle (SET_DEPTH sets, 65536 with the default geometry), and takes no
// access until the sweep is done; register writes are taken throughout. The
// user must write registers only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_controller
  import sacl_pkg::*;
#(
  parameter int unsigned CACHE_BYTES  = DEF_CACHE_BYTES,
  parameter int unsigned WORD_BYTES   = DEF_WORD_BYTES,
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready,
  // access stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] address, [36:32] byte_count
  input  logic [0:0]            in_tuser,   // [0] action
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] set_index, [19:16] way, [20] hit,
                                            // [21] allocated, [22] evicted,
                                            // [23] dirty_writeback, [24] write_through
  output logic                  out_tlast   // last
);

  // geometry derived from the parameters
  localparam int unsigned WORD_LOG     = floor_log2(longint'(WORD_BYTES));
  localparam int unsigned CACHE_LOG    = floor_log2(longint'(CACHE_BYTES));
  localparam int unsigned MAX_WAYS_LOG = floor_log2(longint'(MAX_WAYS));
  localparam int unsigned WAYS_LOG_MAX =
    (MAX_WAYS_LOG > WAYS_LOG_CAP) ? WAYS_LOG_CAP : MAX_WAYS_LOG;
  localparam int unsigned NWAYS        = 1 << WAYS_LOG_MAX;
  localparam int unsigned SET_SPAN     = (CACHE_LOG > WORD_LOG) ? CACHE_LOG - WORD_LOG : 0;
  localparam int unsigned SET_BITS_MAX = (SET_SPAN > SET_BITS_CAP) ? SET_BITS_CAP : SET_SPAN;
  localparam int unsigned SET_DEPTH    = 1 << SET_BITS_MAX;
  localparam int unsigned SET_W        = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
  localparam int unsigned SHIFT_A      = WORD_LOG + SET_BITS_CAP;
  localparam int unsigned SHIFT_B      = CACHE_LOG - WAYS_LOG_MAX;
  localparam int unsigned MIN_SHIFT    = (SHIFT_A < SHIFT_B) ? SHIFT_A : SHIFT_B;
  localparam int unsigned TAG_W        =
    (ADDRESS_BITS > MIN_SHIFT) ? ADDRESS_BITS - MIN_SHIFT : 1;
  localparam int unsigned ENTRY_W      = TAG_W + AGE_W + 2;
  localparam int unsigned AGE_LSB      = TAG_W;
  localparam int unsigned DIRTY_BIT    = TAG_W + AGE_W;
  localparam int unsigned VALID_BIT    = TAG_W + AGE_W + 1;
  localparam int unsigned WORD_W       = NWAYS * ENTRY_W;

  // every way invalid, clean, tag zero, age equal to its way number
  function automatic logic [WORD_W-1:0] reset_word();
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < NWAYS; i++) begin
      w[i*ENTRY_W + AGE_LSB +: AGE_W] = AGE_W'(i);
    end
    return w;
  endfunction

  // registers
  state_t              state_r, state_nxt;
  logic [SET_W-1:0]    clr_r, clr_nxt;
  logic [1:0]          bwl_r, bwl_nxt;
  logic [2:0]          wlog_r, wlog_nxt;
  logic [1:0]          wpol_r, wpol_nxt;
  logic                action_r, action_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SET_W-1:0]    set_r, set_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [NBLK_W-1:0]   left_r, left_nxt;
  logic                fwd_r, fwd_nxt;
  logic [WORD_W-1:0]   fwd_word_r, fwd_word_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [WAY_W-1:0]    way_r, way_nxt;
  logic                hit_r, hit_nxt;
  logic                alloc_r, alloc_nxt;
  logic                evict_r, evict_nxt;
  logic                dwb_r, dwb_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [SET_OUT_W-1:0] out_set_r, out_set_nxt;
  logic [WAY_W-1:0]    out_way_r, out_way_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_alloc_r, out_alloc_nxt;
  logic                out_evict_r, out_evict_nxt;
  logic                out_dwb_r, out_dwb_nxt;
  logic                out_wt_r, out_wt_nxt;
  logic                out_last_r, out_last_nxt;

  // geometry of the current register settings
  logic [2:0]          wl;
  logic [GEO_W-1:0]    bb, bw, sb, sh;
  logic [SET_W-1:0]    set_mask;
  logic [TAG_W-1:0]    tag_mask;
  logic [NWAYS-1:0]    way_en;
  logic [1:0]          pol;
  logic                no_alloc, mark_dirty;

  // access split
  logic [CNT_W-1:0]    in_count;
  logic [OFF_W-1:0]    offset, span, nspan;
  logic [NBLK_W-1:0]   nblk;
  logic [SET_W-1:0]    set_first, set_inc;
  logic [TAG_W-1:0]    tag_first, tag_inc;

  // RAM and lookup
  logic                ram_we;
  logic [SET_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [WORD_W-1:0]   look_word, new_word;
  lookup_t             look;
  logic [AGE_W-1:0]    cur_age;
  logic                out_free;
  logic                cfg_wr;

  // --------------------------------------------------------------------------
  // geometry
  // --------------------------------------------------------------------------
  always_comb begin
    wl = (wlog_r > 3'(WAYS_LOG_MAX)) ? 3'(WAYS_LOG_MAX) : wlog_r;
    bb = GEO_W'(WORD_LOG) + GEO_W'(bwl_r);
    bw = bb + GEO_W'(wl);
    // floor log2 of the set count, at most 16, zero when no set fits
    if (bw > GEO_W'(CACHE_LOG)) begin
      sb = '0;
    end else if (GEO_W'(CACHE_LOG) - bw > GEO_W'(SET_BITS_CAP)) begin
      sb = GEO_W'(SET_BITS_CAP);
    end else begin
      sb = GEO_W'(CACHE_LOG) - bw;
    end
    sh       = bb + sb;
    set_mask = ~({SET_W{1'b1}} << sb);
    tag_mask = TAG_W'({ADDRESS_BITS{1'b1}} >> sh);
    for (int i = 0; i < NWAYS; i++) begin
      way_en[i] = ((WAY_W'(i) >> wl) == '0);
    end
    // policy three acts as write-through no-allocate
    pol        = (wpol_r > POL_WTNA) ? POL_WTNA : wpol_r;
    no_alloc   = (action_r == ACT_WRITE) && (pol == POL_WTNA);
    mark_dirty = (action_r == ACT_WRITE) && (pol == POL_WB);
  end

  // --------------------------------------------------------------------------
  // split the access into blocks
  // --------------------------------------------------------------------------
  always_comb begin
    in_count = in_tdata[ADDR_FIELD_W +: CNT_W];
    if (in_count > CNT_W'(MAX_BYTES)) begin
      in_count = CNT_W'(MAX_BYTES);
    end
    offset = addr_r[OFF_W-1:0] & ~({OFF_W{1'b1}} << bb);
    span   = offset + OFF_W'(count_r) - OFF_W'(1);
    nspan  = span >> bb;
    nblk   = (nspan >= OFF_W'(RESULT_LIMIT)) ? NBLK_W'(RESULT_LIMIT)
                                              : NBLK_W'(nspan) + NBLK_W'(1);
    set_first = SET_W'(addr_r >> bb) & set_mask;
    tag_first = TAG_W'(addr_r >> sh);
    // next block: step the set index, carry into the tag
    set_inc = (set_r + SET_W'(1)) & set_mask;
    tag_inc = (tag_r + TAG_W'(set_r == set_mask)) & tag_mask;
  end

  // --------------------------------------------------------------------------
  // set storage and lookup
  // --------------------------------------------------------------------------
  sacl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SET_DEPTH),
    .AW    (SET_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a write-back to the set just read again is forwarded
  assign look_word = fwd_r ? fwd_word_r : ram_rdata;

  sacl_lookup #(
    .NWAYS (NWAYS),
    .TAG_W (TAG_W)
  ) u_lookup (
    .set_word (look_word),
    .tag      (tag_r),
    .way_en   (way_en),
    .look     (look)
  );

  // age update and fill of the chosen way
  always_comb begin
    logic [ENTRY_W-1:0] e;
    cur_age  = '0;
    new_word = word_r;
    for (int i = 0; i < NWAYS; i++) begin
      if (WAY_W'(i) == way_r) begin
        cur_age = word_r[i*ENTRY_W + AGE_LSB +: AGE_W];
      end
    end
    for (int i = 0; i < NWAYS; i++) begin
      e = word_r[i*ENTRY_W +: ENTRY_W];
      // age every younger way by one, zero the touched way
      if (way_en[i] && (e[AGE_LSB +: AGE_W] < cur_age)) begin
        e[AGE_LSB +: AGE_W] = e[AGE_LSB +: AGE_W] + AGE_W'(1);
      end
      if (WAY_W'(i) == way_r) begin
        e[AGE_LSB +: AGE_W] = '0;
        if (alloc_r) begin
          e[VALID_BIT]   = 1'b1;
          e[DIRTY_BIT]   = mark_dirty;
          e[TAG_W-1:0]   = tag_r;
        end else if (mark_dirty) begin
          e[DIRTY_BIT]   = 1'b1;
        end
      end
      if (hit_r || alloc_r) begin
        new_word[i*ENTRY_W +: ENTRY_W] = e;
      end
    end
  end

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[CFG_AW-1:2])
      REG_BLOCK_WORDS_LOG: cfg_prdata = CFG_DW'(bwl_r);
      REG_WAYS_LOG:        cfg_prdata = CFG_DW'(wlog_r);
      REG_WRITE_POLICY:    cfg_prdata = CFG_DW'(wpol_r);
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    bwl_nxt  = bwl_r;
    wlog_nxt = wlog_r;
    wpol_nxt = wpol_r;
    if (cfg_wr) begin
      case (cfg_paddr[CFG_AW-1:2])
        REG_BLOCK_WORDS_LOG: bwl_nxt  = cfg_pwdata[1:0];
        REG_WAYS_LOG:        wlog_nxt = cfg_pwdata[2:0];
        REG_WRITE_POLICY:    wpol_nxt = cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control: next state, RAM access, result staging
  // --------------------------------------------------------------------------
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    action_nxt     = action_r;
    addr_nxt       = addr_r;
    count_nxt      = count_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    left_nxt       = left_r;
    fwd_nxt        = fwd_r;
    fwd_word_nxt   = fwd_word_r;
    word_nxt       = word_r;
    way_nxt        = way_r;
    hit_nxt        = hit_r;
    alloc_nxt      = alloc_r;
    evict_nxt      = evict_r;
    dwb_nxt        = dwb_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    out_set_nxt    = out_set_r;
    out_way_nxt    = out_way_r;
    out_hit_nxt    = out_hit_r;
    out_alloc_nxt  = out_alloc_r;
    out_evict_nxt  = out_evict_r;
    out_dwb_nxt    = out_dwb_r;
    out_wt_nxt     = out_wt_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = set_r;
    ram_wdata      = new_word;
    ram_raddr      = set_r;

    case (state_r)
      ST_CLEAR: begin
        // sweep the reset pattern through every set
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = reset_word();
        clr_nxt   = clr_r + SET_W'(1);
        if (clr_r == SET_W'(SET_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          action_nxt = in_tuser[0];
          addr_nxt   = in_tdata[ADDRESS_BITS-1:0];
          count_nxt  = in_count;
          // drop an empty access
          if (in_count != '0) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        set_nxt   = set_first;
        tag_nxt   = tag_first;
        left_nxt  = nblk;
        ram_raddr = set_first;
        fwd_nxt   = 1'b0;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        word_nxt  = look_word;
        hit_nxt   = look.hit;
        alloc_nxt = !look.hit && !no_alloc;
        evict_nxt = !look.hit && !no_alloc && !look.free;
        dwb_nxt   = !look.hit && !no_alloc && !look.free && look.victim_dirty;
        if (look.hit) begin
          way_nxt = look.hit_way;
        end else if (look.free) begin
          way_nxt = look.free_way;
        end else begin
          way_nxt = look.victim_way;
        end
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_raddr = set_inc;
        // hold while the result slot is occupied
        if (out_free) begin
          ram_we         = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_set_nxt    = SET_OUT_W'(set_r);
          out_way_nxt    = (hit_r || alloc_r) ? way_r : '0;
          out_hit_nxt    = hit_r;
          out_alloc_nxt  = alloc_r;
          out_evict_nxt  = evict_r;
          out_dwb_nxt    = dwb_r;
          out_wt_nxt     = (action_r == ACT_WRITE) && (pol != POL_WB);
          out_last_nxt   = (left_r == NBLK_W'(1));
          fwd_nxt        = (set_inc == set_r);
          fwd_word_nxt   = new_word;
          set_nxt        = set_inc;
          tag_nxt        = tag_inc;
          left_nxt       = left_r - NBLK_W'(1);
          state_nxt      = (left_r == NBLK_W'(1)) ? ST_IDLE : ST_LOOK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      bwl_r        <= '0;
      wlog_r       <= '0;
      wpol_r       <= '0;
      fwd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      bwl_r        <= bwl_nxt;
      wlog_r       <= wlog_nxt;
      wpol_r       <= wpol_nxt;
      fwd_r        <= fwd_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    addr_r      <= addr_nxt;
    count_r     <= count_nxt;
    set_r       <= set_nxt;
    tag_r       <= tag_nxt;
    left_r      <= left_nxt;
    fwd_word_r  <= fwd_word_nxt;
    word_r      <= word_nxt;
    way_r       <= way_nxt;
    hit_r       <= hit_nxt;
    alloc_r     <= alloc_nxt;
    evict_r     <= evict_nxt;
    dwb_r       <= dwb_nxt;
    out_set_r   <= out_set_nxt;
    out_way_r   <= out_way_nxt;
    out_hit_r   <= out_hit_nxt;
    out_alloc_r <= out_alloc_nxt;
    out_evict_r <= out_evict_nxt;
    out_dwb_r   <= out_dwb_nxt;
    out_wt_r    <= out_wt_nxt;
    out_last_r  <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // result port
  // --------------------------------------------------------------------------
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_wt_r, out_dwb_r, out_evict_r, out_alloc_r, out_hit_r,
                       out_way_r, out_set_r};

endmodule
